/* design/task_burn_group_classifier_macros.svh */
// Assertion macros used by the classifier checker.
`ifndef TASK_BURN_GROUP_CLASSIFIER_MACROS_SVH
`define TASK_BURN_GROUP_CLASSIFIER_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define TBGC_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error("tbgc check failed");

// Clocked assertion that also holds across reset.
`define TBGC_ASSERT_RST(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("tbgc reset check failed");

`endif

/* design/tbgc_pkg.sv */
// Types and constants of the task burn group classifier.
package tbgc_pkg;

  localparam int unsigned CfgIndexW = 3;

  localparam logic [CfgIndexW-1:0] CFG_BURST_LIMIT     = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_WINDOW_LENGTH   = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_BURN_HOT_LIMIT  = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_BURN_LOW_LIMIT  = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_PROMOTE_WINDOWS = 3'd4;

  localparam logic REQ_STOP   = 1'b0;
  localparam logic REQ_ENABLE = 1'b1;

  localparam logic GROUP_LIGHT = 1'b0;
  localparam logic GROUP_HOG   = 1'b1;

  localparam logic [31:0] BURN_MAX  = 32'hffff_ffff;
  localparam logic [7:0]  COUNT_MAX = 8'd255;

  localparam logic [31:0] RST_BURST_LIMIT     = 32'd2000000;
  localparam logic [31:0] RST_WINDOW_LENGTH   = 32'd100000000;
  localparam logic [31:0] RST_BURN_HOT_LIMIT  = 32'd50000000;
  localparam logic [31:0] RST_BURN_LOW_LIMIT  = 32'd10000000;
  localparam logic [7:0]  RST_PROMOTE_WINDOWS = 8'd3;

  typedef struct packed {
    logic [31:0] burst_limit;
    logic [31:0] window_length;
    logic [31:0] burn_hot_limit;
    logic [31:0] burn_low_limit;
    logic [7:0]  promote_windows;
  } cfg_t;

  typedef struct packed {
    logic        req_type;
    logic [63:0] now;
    logic [63:0] delta;
  } req_t;

  typedef struct packed {
    logic       group_now;
    logic [7:0] quiet_count;
    logic       demoted;
    logic       promoted;
  } res_t;

  typedef struct packed {
    logic        group_flag;
    logic [7:0]  quiet_runs;
    logic [63:0] window_start;
    logic [31:0] burn_total;
  } task_state_t;

endpackage

/* design/tbgc_cfg_regs.sv */
// Configuration register file of the classifier.
module tbgc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tbgc_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output tbgc_pkg::cfg_t                cfg
);
  import tbgc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.burst_limit     <= RST_BURST_LIMIT;
      cfg.window_length   <= RST_WINDOW_LENGTH;
      cfg.burn_hot_limit  <= RST_BURN_HOT_LIMIT;
      cfg.burn_low_limit  <= RST_BURN_LOW_LIMIT;
      cfg.promote_windows <= RST_PROMOTE_WINDOWS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BURST_LIMIT:     cfg.burst_limit     <= cfg_data;
        CFG_WINDOW_LENGTH:   cfg.window_length   <= cfg_data;
        CFG_BURN_HOT_LIMIT:  cfg.burn_hot_limit  <= cfg_data;
        CFG_BURN_LOW_LIMIT:  cfg.burn_low_limit  <= cfg_data;
        CFG_PROMOTE_WINDOWS: cfg.promote_windows <= cfg_data[7:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

/* design/tbgc_step.sv */
// Combinational classify step: next task state and result for one item.
module tbgc_step (
  input  tbgc_pkg::cfg_t        cfg,
  input  tbgc_pkg::task_state_t st,
  input  tbgc_pkg::req_t        item,
  output tbgc_pkg::task_state_t st_next,
  output tbgc_pkg::res_t        result
);
  import tbgc_pkg::*;

  logic [64:0] burn_sum;
  logic [31:0] burn_sat;
  logic        hot_burst;
  logic [63:0] elapsed;
  logic        win_ready;
  logic [7:0]  quiet_inc;
  logic        demoted;
  logic        promoted;

  // burn + delta saturates at 32 bits
  assign burn_sum  = {1'b0, item.delta} + {33'd0, st.burn_total};
  assign burn_sat  = (|burn_sum[64:32]) ? BURN_MAX : burn_sum[31:0];
  assign hot_burst = item.delta > {32'd0, cfg.burst_limit};

  // time going backwards never makes the window ready
  assign elapsed   = item.now - st.window_start;
  assign win_ready = (item.now >= st.window_start) &&
                     (elapsed >= {32'd0, cfg.window_length});

  assign quiet_inc = (st.quiet_runs != COUNT_MAX) ? st.quiet_runs + 8'd1 : st.quiet_runs;

  always_comb begin
    st_next  = st;
    demoted  = 1'b0;
    promoted = 1'b0;
    if (item.req_type == REQ_ENABLE) begin
      st_next = '0;
    end else begin
      st_next.burn_total = burn_sat;
      priority if (hot_burst) begin
        st_next.quiet_runs = 8'd0;
        if (st.group_flag == GROUP_LIGHT) begin
          st_next.group_flag   = GROUP_HOG;
          st_next.window_start = item.now;
          st_next.burn_total   = 32'd0;
          demoted              = 1'b1;
        end
      end else if (st.window_start == 64'd0) begin
        st_next.window_start = item.now;
      end else if (win_ready) begin
        if (burn_sat > cfg.burn_hot_limit) begin
          if (st.group_flag == GROUP_LIGHT) begin
            st_next.group_flag = GROUP_HOG;
            demoted            = 1'b1;
          end
          st_next.quiet_runs = 8'd0;
        end else if (burn_sat < cfg.burn_low_limit) begin
          if (st.group_flag == GROUP_HOG) begin
            if (quiet_inc >= cfg.promote_windows) begin
              st_next.group_flag = GROUP_LIGHT;
              st_next.quiet_runs = 8'd0;
              promoted           = 1'b1;
            end else begin
              st_next.quiet_runs = quiet_inc;
            end
          end else if (st.quiet_runs < cfg.promote_windows) begin
            st_next.quiet_runs = st.quiet_runs + 8'd1;
          end
        end else begin
          st_next.quiet_runs = 8'd0;
        end
        st_next.window_start = item.now;
        st_next.burn_total   = 32'd0;
      end else begin
        // window still open: only the burn moves
      end
    end
  end

  assign result.group_now   = st_next.group_flag;
  assign result.quiet_count = st_next.quiet_runs;
  assign result.demoted     = demoted;
  assign result.promoted    = promoted;

endmodule

/* design/task_burn_group_classifier.sv */
// Top level of the task burn group classifier: input register, step, result register.
//
// Classifies one task as light or hog. Each transfer on the req channel is
// either a stop event (req_type 0: now and delta in ns) or an enable
// (req_type 1) that puts the task context back to its fresh state; every
// request yields exactly one transfer on the res channel carrying the group
// after the step, the quiet window counter and the demoted/promoted flags.
// One request is taken per clock while req_stall is low: a request goes
// into the input register, the classify step runs in the next cycle
// against the task state registers and lands in the result register. The
// task state feedback loop (burn, window start, counter, group) closes
// through the combinational step, which is what sets the one-per-clock
// rate. While a result waits under res_stall, one more request is still
// taken into the input register; only then does req_stall rise.
// Configuration writes via cfg_we/cfg_index/cfg_data take effect on the
// next clock and must only be done while no request is in flight;
// unmapped indexes are ignored.
module task_burn_group_classifier (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          req_valid,
  output logic                          req_stall,
  input  tbgc_pkg::req_t                req,
  // result channel
  output logic                          res_valid,
  input  logic                          res_stall,
  output tbgc_pkg::res_t                res,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [tbgc_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import tbgc_pkg::*;

  cfg_t        cfg;
  task_state_t st;
  task_state_t st_next;
  res_t        step_res;

  // input register
  logic        s1_valid;
  req_t        s1_item;

  logic        advance;   // result register can take the input register
  logic        req_take;  // request transfer this cycle

  assign advance   = !res_valid || !res_stall;
  assign req_stall = s1_valid && !advance;
  assign req_take  = req_valid && !req_stall;

  tbgc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tbgc_step u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (s1_item),
    .st_next (st_next),
    .result  (step_res)
  );

  // control and task state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
      st        <= '0;
    end else begin
      if (req_take) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        res_valid <= s1_valid;
        // state commits only when the item moves into the result register
        if (s1_valid) begin
          st <= st_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_take) begin
      s1_item <= req;
    end
    if (advance && s1_valid) begin
      res <= step_res;
    end
  end

endmodule

/* design/tbgc_checker.sv */
// Port-level checks of the classifier and their bind.
`include "task_burn_group_classifier_macros.svh"

module tbgc_checker (
  input logic           clk,
  input logic           rst,
  input logic           res_valid,
  input logic           res_stall,
  input tbgc_pkg::res_t res
);
  import tbgc_pkg::*;

  `TBGC_ASSERT_RST(a_rst_no_res, clk, rst |=> !res_valid)
  `TBGC_ASSERT(a_res_hold, clk, rst, res_valid && res_stall |=> res_valid && $stable(res))
  `TBGC_ASSERT(a_not_both, clk, rst, res_valid |-> !(res.demoted && res.promoted))
  `TBGC_ASSERT(a_promote_light, clk, rst, res_valid && res.promoted |-> res.group_now == GROUP_LIGHT && res.quiet_count == 8'd0)
  `TBGC_ASSERT(a_demote_hog, clk, rst, res_valid && res.demoted |-> res.group_now == GROUP_HOG && res.quiet_count == 8'd0)

endmodule

bind task_burn_group_classifier tbgc_checker u_tbgc_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
